// ===== rtl/core/dvru_pkg.sv =====
// Shared constants and types for the distance-vector route update block.
`timescale 1ns / 1ps
package dvru_pkg;

    localparam int TABLE_DEPTH   = 64;
    localparam int COST_INFINITY = 16;
    localparam int IDX_W         = $clog2(TABLE_DEPTH);
    localparam int CNT_W         = $clog2(TABLE_DEPTH + 1);
    localparam int COST_W        = 5;
    localparam int ADDR_W        = 32;
    localparam int OP_W          = 2;
    localparam int ACT_W         = 3;
    localparam int IN_DATA_W     = 104;
    localparam int OUT_DATA_W    = 16;

    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
    localparam logic [OP_W-1:0] OP_LOCAL  = 2'd1;
    localparam logic [OP_W-1:0] OP_ADVERT = 2'd2;
    localparam logic [OP_W-1:0] OP_NONE   = 2'd3;

    localparam logic [ACT_W-1:0] ACT_INSERTED = 3'd0;
    localparam logic [ACT_W-1:0] ACT_IMPROVED = 3'd1;
    localparam logic [ACT_W-1:0] ACT_KEPT     = 3'd2;
    localparam logic [ACT_W-1:0] ACT_DROPPED  = 3'd3;
    localparam logic [ACT_W-1:0] ACT_CLEARED  = 3'd4;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [ADDR_W-1:0] dest;
        logic [COST_W-1:0] cost;
        logic [ADDR_W-1:0] next_hop;
        logic [ADDR_W-1:0] iface;
    } cmd_t;

    typedef struct packed {
        logic [IDX_W-1:0]  idx;
        logic [ACT_W-1:0]  act;
        logic [COST_W-1:0] cost;
    } res_t;

endpackage

// ===== rtl/core/dvru_front.sv =====
// Front end: unpacks the input word and turns it into a table command.
`timescale 1ns / 1ps
module dvru_front (
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [dvru_pkg::IN_DATA_W-1:0]   s_tdata,   // dest_addr, adv_cost, neighbor_addr, iface_addr
    input  logic [dvru_pkg::OP_W-1:0]        s_tuser,   // operation
    output logic                             push,
    output dvru_pkg::cmd_t                   push_cmd,
    input  logic                             q_full
);
    import dvru_pkg::*;

    logic [ADDR_W-1:0] dest;
    logic [COST_W-1:0] adv;
    logic [ADDR_W-1:0] nbr;
    logic [ADDR_W-1:0] ifc;
    logic [COST_W:0]   sum;
    logic [COST_W-1:0] new_cost;

    assign dest = s_tdata[ADDR_W-1:0];
    assign adv  = s_tdata[ADDR_W+COST_W-1:ADDR_W];
    assign nbr  = s_tdata[2*ADDR_W+COST_W-1:ADDR_W+COST_W];
    assign ifc  = s_tdata[3*ADDR_W+COST_W-1:2*ADDR_W+COST_W];

    assign sum      = {1'b0, adv} + (COST_W+1)'(1);
    assign new_cost = (sum > (COST_W+1)'(COST_INFINITY)) ? COST_W'(COST_INFINITY)
                                                         : sum[COST_W-1:0];

    assign s_tready = !q_full;
    assign push     = s_tvalid && !q_full;

    always_comb begin
        push_cmd.op = s_tuser;
        push_cmd.dest = dest;
        if (s_tuser == OP_LOCAL) begin
            push_cmd.cost     = '0;
            push_cmd.next_hop = dest;
            push_cmd.iface    = dest;
        end else begin
            push_cmd.cost     = new_cost;
            push_cmd.next_hop = nbr;
            push_cmd.iface    = ifc;
        end
    end

endmodule

// ===== rtl/core/dvru_queue.sv =====
// Two-entry command queue between the front end and the table engine.
`timescale 1ns / 1ps
module dvru_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  dvru_pkg::cmd_t push_cmd,
    output logic           full,
    input  logic           pop,
    output logic           q_valid,
    output dvru_pkg::cmd_t q_cmd
);
    import dvru_pkg::*;

    cmd_t       slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;

    assign full    = cnt_reg == 2'd2;
    assign q_valid = cnt_reg != 2'd0;
    assign q_cmd   = slot_reg[rd_ptr_reg];

    always_comb begin
        cnt_next = cnt_reg;
        if (push && !pop) begin
            cnt_next = cnt_reg + 2'd1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            cnt_reg <= cnt_next;
        end
    end

endmodule

// ===== rtl/core/dvru_back.sv =====
// Table engine: route memories, sequential destination search and result register.
`timescale 1ns / 1ps
module dvru_back (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           q_valid,
    input  dvru_pkg::cmd_t q_cmd,
    output logic           pop,
    output logic           res_valid,
    output dvru_pkg::res_t res,
    input  logic           res_ready
);
    import dvru_pkg::*;

    typedef enum logic {ST_IDLE, ST_SEARCH} state_t;

    logic [ADDR_W-1:0] dest_mem     [TABLE_DEPTH];
    logic [ADDR_W-1:0] next_hop_mem [TABLE_DEPTH];
    logic [ADDR_W-1:0] iface_mem    [TABLE_DEPTH];
    logic [COST_W-1:0] cost_mem     [TABLE_DEPTH];

    state_t            state_reg;
    cmd_t              cmd_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  scan_reg;
    logic              rd_vld_reg;
    logic [IDX_W-1:0]  rd_idx_reg;
    logic [ADDR_W-1:0] rd_dest_reg;
    logic [COST_W-1:0] rd_cost_reg;
    logic              res_valid_reg;
    res_t              res_reg;

    logic              out_free;
    logic              full;
    logic              issue;
    logic              hit;
    logic              miss;
    logic              improve;
    logic              res_load;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_idx;
    cmd_t              wr_cmd;

    assign out_free = !res_valid_reg || res_ready;
    assign pop      = (state_reg == ST_IDLE) && q_valid && out_free;
    assign full     = count_reg == CNT_W'(TABLE_DEPTH);
    assign issue    = (state_reg == ST_SEARCH) && (scan_reg < count_reg);
    assign hit      = (state_reg == ST_SEARCH) && rd_vld_reg && (rd_dest_reg == cmd_reg.dest);
    assign miss     = (state_reg == ST_SEARCH) && !rd_vld_reg && (scan_reg == count_reg);
    assign improve  = hit && (cmd_reg.cost < rd_cost_reg);
    assign res_load = (pop && q_cmd.op != OP_ADVERT) || hit || miss;

    always_comb begin
        wr_en  = 1'b0;
        wr_idx = count_reg[IDX_W-1:0];
        wr_cmd = cmd_reg;
        if (pop && q_cmd.op == OP_LOCAL && !full) begin
            wr_en  = 1'b1;
            wr_cmd = q_cmd;
        end else if (miss && !full) begin
            wr_en = 1'b1;
        end else if (improve) begin
            wr_en  = 1'b1;
            wr_idx = rd_idx_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            dest_mem[wr_idx]     <= wr_cmd.dest;
            next_hop_mem[wr_idx] <= wr_cmd.next_hop;
            iface_mem[wr_idx]    <= wr_cmd.iface;
            cost_mem[wr_idx]     <= wr_cmd.cost;
        end
        rd_dest_reg <= dest_mem[scan_reg[IDX_W-1:0]];
        rd_cost_reg <= cost_mem[scan_reg[IDX_W-1:0]];
        rd_idx_reg  <= scan_reg[IDX_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            scan_reg      <= '0;
            rd_vld_reg    <= 1'b0;
            res_valid_reg <= 1'b0;
        end else begin
            if (res_load) begin
                res_valid_reg <= 1'b1;
            end else if (res_ready) begin
                res_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    scan_reg   <= '0;
                    rd_vld_reg <= 1'b0;
                    if (pop) begin
                        cmd_reg <= q_cmd;
                        unique case (q_cmd.op)
                            OP_CLEAR: begin
                                count_reg <= '0;
                                res_reg   <= '{idx: '0, act: ACT_CLEARED, cost: '0};
                            end
                            OP_LOCAL: begin
                                if (full) begin
                                    res_reg <= '{idx: '0, act: ACT_DROPPED, cost: '0};
                                end else begin
                                    count_reg <= count_reg + CNT_W'(1);
                                    res_reg   <= '{idx: count_reg[IDX_W-1:0],
                                                   act: ACT_INSERTED, cost: '0};
                                end
                            end
                            OP_ADVERT: begin
                                state_reg <= ST_SEARCH;
                            end
                            OP_NONE: begin
                                res_reg <= '{idx: '0, act: ACT_KEPT, cost: '0};
                            end
                            default: begin
                                res_reg <= '{idx: '0, act: ACT_KEPT, cost: '0};
                            end
                        endcase
                    end
                end
                ST_SEARCH: begin
                    rd_vld_reg <= issue;
                    if (issue) begin
                        scan_reg <= scan_reg + CNT_W'(1);
                    end
                    if (hit) begin
                        state_reg <= ST_IDLE;
                        if (improve) begin
                            res_reg <= '{idx: rd_idx_reg, act: ACT_IMPROVED, cost: cmd_reg.cost};
                        end else begin
                            res_reg <= '{idx: rd_idx_reg, act: ACT_KEPT, cost: rd_cost_reg};
                        end
                    end else if (miss) begin
                        state_reg <= ST_IDLE;
                        if (full) begin
                            res_reg <= '{idx: '0, act: ACT_DROPPED, cost: cmd_reg.cost};
                        end else begin
                            count_reg <= count_reg + CNT_W'(1);
                            res_reg   <= '{idx: count_reg[IDX_W-1:0],
                                           act: ACT_INSERTED, cost: cmd_reg.cost};
                        end
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

// ===== rtl/core/distance_vector_route_update.sv =====
// Top level of the distance-vector route table update block.
// Each input word carries one table operation and yields exactly one result word.
// Words enter a two-entry command queue, so input is taken while a result waits.
// Clear, local add and the unused selector complete as they leave the queue. An advertised
// entry scans the valid routes in slot order through the single read port of the
// destination memory, one entry per cycle, and stops at the first matching slot or
// after the last valid entry of the 64-entry table. A result word not yet taken holds
// the engine.
// Table contents are undefined after reset; the valid entry count resets to zero.
`timescale 1ns / 1ps
module distance_vector_route_update (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [dvru_pkg::IN_DATA_W-1:0]    s_tdata,   // dest_addr, adv_cost, neighbor_addr, iface_addr, zero pad
    input  logic [dvru_pkg::OP_W-1:0]         s_tuser,   // operation
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [dvru_pkg::OUT_DATA_W-1:0]   m_tdata,   // entry_index, stored_cost, zero pad
    output logic [dvru_pkg::ACT_W-1:0]        m_tuser    // action
);
    import dvru_pkg::*;

    logic push;
    cmd_t push_cmd;
    logic q_full;
    logic pop;
    logic q_valid;
    cmd_t q_cmd;
    res_t res;

    dvru_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .push     (push),
        .push_cmd (push_cmd),
        .q_full   (q_full)
    );

    dvru_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (pop),
        .q_valid  (q_valid),
        .q_cmd    (q_cmd)
    );

    dvru_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_valid   (q_valid),
        .q_cmd     (q_cmd),
        .pop       (pop),
        .res_valid (m_tvalid),
        .res       (res),
        .res_ready (m_tready)
    );

    assign m_tdata = {(OUT_DATA_W-IDX_W-COST_W)'(0), res.cost, res.idx};
    assign m_tuser = res.act;

endmodule
